FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; every file that asserts includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define MWPO_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high.
`define MWPO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/mwpo_pkg.sv
// Package of the phase oscillator: register indexes, waveform codes,
// default parameter values and port widths. Depends on nothing.
package mwpo_pkg;

   localparam int PHASE_BITS_DEF       = 32;
   localparam int OUT_BITS_DEF         = 16;
   localparam int SINE_TABLE_DEPTH_DEF = 1024;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;
   localparam int WAVE_BITS      = 3;
   localparam int STEP_BITS      = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVEFORM   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP = 1'd1;

   localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 3'd0;
   localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd1;
   localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 3'd2;
   localparam logic [WAVE_BITS-1:0] WAVE_SAWTOOTH = 3'd3;

endpackage

FILE: rtl/mwpo_phase_acc.sv
// Phase accumulator: holds the running phase, applies restart and hands
// the phase of each accepted tick to the shaper. Depends on mwpo_pkg.
module mwpo_phase_acc #(
   parameter int PHASE_BITS = mwpo_pkg::PHASE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           restart,
   input  logic [mwpo_pkg::STEP_BITS-1:0] phase_step,
   output logic [PHASE_BITS-1:0]          tick_phase
);
   import mwpo_pkg::*;

   logic [PHASE_BITS-1:0]           phase_ff, phase_in;
   logic [PHASE_BITS-1:0]           tick_phase_ff;
   logic [PHASE_BITS-1:0]           cur_phase;
   logic [PHASE_BITS+STEP_BITS-1:0] step_wide;
   logic [PHASE_BITS-1:0]           step_aligned;

   // step * 2^PHASE_BITS / 2^32, wrapped to the accumulator width
   assign step_wide    = {phase_step, PHASE_BITS'(0)};
   assign step_aligned = step_wide[PHASE_BITS+STEP_BITS-1 -: PHASE_BITS];

   assign cur_phase = restart ? '0 : phase_ff;
   assign phase_in  = accept ? cur_phase + step_aligned : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tick_phase_ff <= cur_phase;
      end
   end

   assign tick_phase = tick_phase_ff;

endmodule

FILE: rtl/mwpo_shaper.sv
// Waveform shaper: quarter-wave sine ROM lookup plus triangle, square and
// sawtooth arithmetic, registered once. Depends on mwpo_pkg.
module mwpo_shaper #(
   parameter int PHASE_BITS       = mwpo_pkg::PHASE_BITS_DEF,
   parameter int OUT_BITS         = mwpo_pkg::OUT_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = mwpo_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic [mwpo_pkg::WAVE_BITS-1:0] waveform,
   input  logic [PHASE_BITS-1:0]          tick_phase,
   output logic [OUT_BITS-1:0]            sine_mag,
   output logic                           sine_neg,
   output logic                           use_sine,
   output logic signed [OUT_BITS-1:0]     lin_sample
);
   import mwpo_pkg::*;

   localparam int DW    = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int MW    = PHASE_BITS - 2 + DW;
   localparam int SH    = PHASE_BITS + 1 - OUT_BITS;
   localparam int SHR   = (SH > 0) ? SH : 0;
   localparam int SHL   = (SH < 0) ? -SH : 0;
   localparam int XW    = PHASE_BITS + OUT_BITS + 2;
   localparam int SW    = PHASE_BITS + 3;
   localparam longint OMAX       = (longint'(1) << (OUT_BITS - 1)) - 1;
   localparam longint HALF_PI_Q30 = 64'd1686629713;
   localparam longint ONE_Q30    = longint'(1) << 30;

   typedef logic [OUT_BITS-1:0] rom_type [0:SINE_TABLE_DEPTH];

   // Taylor series in Q30 with truncation, evaluated at elaboration
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [63:0] term;
      longint      sum;
      longint      r;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 9; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            unique case (n)
               1: term = term / 6;
               2: term = term / 20;
               3: term = term / 42;
               4: term = term / 72;
               5: term = term / 110;
               6: term = term / 156;
               7: term = term / 210;
               8: term = term / 272;
               default: term = term / 342;
            endcase
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) sum = 0;
         if (sum > ONE_Q30) sum = ONE_Q30;
         r = longint'((64'(sum) * 64'(OMAX) + (64'd1 << 29)) >> 30);
         if (r > OMAX) r = OMAX;
         rom[k] = OUT_BITS'(r);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [1:0]            quad;
   logic [MW-1:0]         idx_prod;
   logic [DW-1:0]         idx_raw, idx;
   logic signed [SW-1:0]  ps, full, tri_d, tri_v;
   logic [PHASE_BITS+1:0] u_tri, u_saw, u;
   logic [OUT_BITS:0]     r;
   logic signed [OUT_BITS-1:0] scaled, lin;

   logic [OUT_BITS-1:0]        sine_mag_ff;
   logic                       sine_neg_ff, use_sine_ff;
   logic signed [OUT_BITS-1:0] lin_ff;

   // sine: quadrant from the top two bits, index from the rest times depth
   assign quad     = tick_phase[PHASE_BITS-1 -: 2];
   assign idx_prod = MW'(tick_phase[PHASE_BITS-3:0]) * MW'(SINE_TABLE_DEPTH);
   assign idx_raw  = idx_prod[MW-1 -: DW];
   assign idx      = quad[0] ? DW'(SINE_TABLE_DEPTH) - idx_raw : idx_raw;

   assign ps   = signed'(SW'(tick_phase));
   assign full = signed'(SW'(1) << PHASE_BITS);

   always_comb begin
      if (!tick_phase[PHASE_BITS-1]) begin
         tri_d = ps - (full >>> 2);
         tri_d = (tri_d < 0) ? -tri_d : tri_d;
         tri_v = full - (tri_d <<< 2);
      end else begin
         tri_d = ps - (full >>> 2) - (full >>> 1);
         tri_d = (tri_d < 0) ? -tri_d : tri_d;
         tri_v = (tri_d <<< 2) - full;
      end
   end

   // offset by one full scale so the value is in [0, 2F]
   assign u_tri = (PHASE_BITS + 2)'(tri_v + full);
   assign u_saw = ((PHASE_BITS + 2)'(1) << (PHASE_BITS + 1)) - {1'b0, tick_phase, 1'b0};
   assign u     = (waveform == WAVE_TRIANGLE) ? u_tri : u_saw;
   assign r     = (OUT_BITS + 1)'((XW'(u) >> SHR) << SHL);

   // r - 2^(OUT_BITS-1), with the top code saturated
   assign scaled = r[OUT_BITS] ? signed'(OUT_BITS'(OMAX))
                               : signed'({~r[OUT_BITS-1], r[OUT_BITS-2:0]});

   always_comb begin
      unique case (waveform)
         WAVE_TRIANGLE, WAVE_SAWTOOTH: lin = scaled;
         WAVE_SQUARE: lin = tick_phase[PHASE_BITS-1] ? signed'({1'b1, (OUT_BITS-1)'(0)})
                                                     : signed'(OUT_BITS'(OMAX));
         default: lin = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sine_mag_ff <= SINE_ROM[idx];
         sine_neg_ff <= quad[1];
         use_sine_ff <= (waveform == WAVE_SINE);
         lin_ff      <= lin;
      end
   end

   assign sine_mag   = sine_mag_ff;
   assign sine_neg   = sine_neg_ff;
   assign use_sine   = use_sine_ff;
   assign lin_sample = lin_ff;

endmodule

FILE: rtl/multi_waveform_phase_oscillator_core.sv
// Numerically controlled oscillator, top level: sine, triangle, square and
// falling sawtooth from a phase accumulator.
// Channels: req_ (one tick, restart flag) in, rsp_ (one signed sample) out,
// each with valid and stall; a transfer happens when valid is high and stall
// low. csr_ is a write port with valid/ready, index 0 waveform, 1 phase_step,
// always ready; write only while no tick is in flight.
// After a req_ transfer the tick passes the phase register, the ROM and
// shaper register and the output register; then rsp_valid rises and the
// sample can transfer. Throughput: one tick per cycle while rsp_stall is
// low; each of the three stages holds one tick.
// Each tick's sample uses the phase before the step is added; restart
// clears the phase first.
// Reset (synchronous) clears phase, the csr registers and all stage valids.
// When the receiver stalls, the output holds; stages behind it keep filling
// empty slots, so up to two further ticks are taken before req_stall rises.
module multi_waveform_phase_oscillator_core #(
   parameter int PHASE_BITS       = mwpo_pkg::PHASE_BITS_DEF,
   parameter int OUT_BITS         = mwpo_pkg::OUT_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = mwpo_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [OUT_BITS-1:0]          rsp_sample,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mwpo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mwpo_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mwpo_pkg::*;

   logic [WAVE_BITS-1:0] waveform_ff, waveform_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                 en1, en2, en3, accept;
   logic [PHASE_BITS-1:0] tick_phase;
   logic [OUT_BITS-1:0]   sine_mag;
   logic                  sine_neg, use_sine;
   logic signed [OUT_BITS-1:0] lin_sample;
   logic signed [OUT_BITS-1:0] sample_ff, sample_in;

   // register file
   assign csr_ready = 1'b1;
   always_comb begin
      waveform_in = waveform_ff;
      step_in     = step_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WAVEFORM:   waveform_in = csr_wdata[WAVE_BITS-1:0];
            CSR_PHASE_STEP: step_in     = csr_wdata[STEP_BITS-1:0];
            default:        ;
         endcase
      end
   end

   // stage enables: a stage moves when it is empty or the next one moves
   assign en3    = !v3_ff || !rsp_stall;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign accept = req_valid && en1;
   assign req_stall = !en1;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff <= WAVE_SINE;
         step_ff     <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
      end else begin
         waveform_ff <= waveform_in;
         step_ff     <= step_in;
         v1_ff       <= v1_in;
         v2_ff       <= v2_in;
         v3_ff       <= v3_in;
      end
   end

   mwpo_phase_acc #(
      .PHASE_BITS(PHASE_BITS)
   ) u_phase_acc (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .restart    (req_restart),
      .phase_step (step_ff),
      .tick_phase (tick_phase)
   );

   mwpo_shaper #(
      .PHASE_BITS       (PHASE_BITS),
      .OUT_BITS         (OUT_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_shaper (
      .clock      (clock),
      .load       (en2 && v1_ff),
      .waveform   (waveform_ff),
      .tick_phase (tick_phase),
      .sine_mag   (sine_mag),
      .sine_neg   (sine_neg),
      .use_sine   (use_sine),
      .lin_sample (lin_sample)
   );

   assign sample_in = !use_sine ? lin_sample
                    : sine_neg  ? -signed'(sine_mag)
                    : signed'(sine_mag);

   always_ff @(posedge clock) begin
      if (en3 && v2_ff) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp_valid  = v3_ff;
   assign rsp_sample = sample_ff;

endmodule

FILE: rtl/mwpo_checker.sv
// Port-level checker for the oscillator top level, attached by bind.
// Depends on mwpo_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mwpo_checker #(
   parameter int OUT_BITS = mwpo_pkg::OUT_BITS_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_restart,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [OUT_BITS-1:0]          rsp_sample,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [mwpo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [mwpo_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mwpo_pkg::*;

   // reset empties the output stage
   `MWPO_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // a free output slot means the input side never stalls
   `MWPO_ASSERT(a_no_stall_when_free, clock, reset, !rsp_valid || !rsp_stall, !req_stall)
   // a held result keeps its value
   `MWPO_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_sample))
   // register port never back-pressures
   `MWPO_ASSERT(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind multi_waveform_phase_oscillator_core mwpo_checker #(
   .OUT_BITS(OUT_BITS)
) u_mwpo_checker (.*);
